// File: design/lob_pkg.sv
// lob_pkg: shared types and codes for the top-of-book order table
// no dependencies
`timescale 1ns / 1ps
package lob_pkg;
	localparam logic [2:0] REQ_ADD = 3'd0;
	localparam logic [2:0] REQ_CANCEL = 3'd1;
	localparam logic [2:0] REQ_EXECUTE = 3'd2;
	localparam logic [2:0] REQ_DELETE = 3'd3;
	localparam logic [2:0] REQ_REPLACE = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_SIDE = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_NOT_RESTING = 3'd3;
	localparam logic [2:0] ST_CLAMPED = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	localparam logic [7:0] SIDE_BID = 8'd66;
	localparam logic [7:0] SIDE_ASK = 8'd83;
	localparam logic [39:0] QTY40_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [8:0] CNT9_MAX = 9'd511;

	typedef struct packed {
		logic [2:0] req_type;
		logic [63:0] order_ref;
		logic [63:0] new_order_ref;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [7:0] side_code;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] error_total;
		logic bid_valid;
		logic [31:0] bid_price;
		logic [39:0] bid_total_qty;
		logic [8:0] bid_orders;
		logic ask_valid;
		logic [31:0] ask_price;
		logic [39:0] ask_total_qty;
		logic [8:0] ask_orders;
	} rsp_t;

	// one order table entry, flags included
	typedef struct packed {
		logic used;
		logic resting;
		logic [63:0] ref_id;
		logic [31:0] price;
		logic [31:0] qty;
		logic is_ask;
	} slot_t;

	// one side's best level accumulator
	typedef struct packed {
		logic found;
		logic [31:0] price;
		logic [39:0] total;
		logic [8:0] cnt;
	} level_t;

	function automatic level_t level_step(level_t l, logic is_ask, logic [31:0] p,
			logic [31:0] q);
		level_t n;
		logic [40:0] sum;
		n = l;
		if (!l.found || (is_ask ? (p < l.price) : (p > l.price))) begin
			n.found = 1'b1;
			n.price = p;
			n.total = '0;
			n.cnt = '0;
		end
		sum = {1'b0, n.total} + {9'd0, q};
		n.total = sum[40] ? QTY40_MAX : sum[39:0];
		if (n.cnt != CNT9_MAX)
			n.cnt = n.cnt + 9'd1;
		return n;
	endfunction
endpackage

// File: design/lob_slot_ram.sv
// lob_slot_ram: order table memory, one write and one registered read port
// depends on lob_pkg
`timescale 1ns / 1ps
module lob_slot_ram #(
	parameter int Depth = 256,
	parameter int AddrW = 8
) (
	input logic clk,
	input logic we,
	input logic [AddrW-1:0] waddr,
	input lob_pkg::slot_t wdata,
	input logic [AddrW-1:0] raddr,
	output lob_pkg::slot_t rdata
);
	import lob_pkg::*;
	slot_t mem [Depth];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: design/limit_order_book_top_of_book.sv
// limit_order_book_top_of_book: per-order book with best bid / best ask report
// depends on lob_pkg and lob_slot_ram
//
//   channel | signals                 | direction | payload
//   req     | req_valid / req_stall   | in        | lob_pkg::req_t
//   rsp     | rsp_valid / rsp_stall   | out       | lob_pkg::rsp_t
//
// a find sweep over the table, one apply state, then a scan sweep that rebuilds
// the best levels; the sweeps read the entries through the single read port, and
// the result is registered in the output register once the scan sweep is over
// a replace that finds its old order runs a second find and apply before the scan
// after reset a clearing pass writes every entry, req_stall high
// a result waits in the output register while rsp_stall is high; the next request
// is taken the cycle after that result transfers
`timescale 1ns / 1ps
module limit_order_book_top_of_book #(
	parameter int MAX_ORDERS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input lob_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output lob_pkg::rsp_t rsp
);
	import lob_pkg::*;
	localparam int AW = $clog2(MAX_ORDERS);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_FIND, S_APPLY, S_SCAN, S_OUT
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [AW:0] idx_q;        // issue counter of a sweep
	logic [AW:0] ridx_q;       // index of the data returning from memory
	logic rvld_q;
	logic old_hit_q, new_hit_q, free_hit_q;
	logic [AW-1:0] old_idx_q, free_idx_q;
	slot_t old_q;
	level_t bid_q, ask_q;
	logic [2:0] st_q;
	logic [31:0] err_q;

	logic we;
	logic [AW-1:0] waddr;
	slot_t wdata, rdata;
	logic [AW-1:0] raddr;

	lob_slot_ram #(.Depth(MAX_ORDERS), .AddrW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign raddr = idx_q[AW-1:0];
	assign req_stall = (state_q != S_IDLE);

	// table update, worked out once the find sweep is over
	logic is_repl, is_del, is_red, is_add, add_try;
	logic [7:0] add_side;
	logic [63:0] add_ref;
	logic dup;
	logic [2:0] st_n;
	logic [AW-1:0] ridx;
	logic [32:0] diff;

	always_comb begin
		is_add = (req_q.req_type == REQ_ADD);
		is_red = (req_q.req_type == REQ_CANCEL) || (req_q.req_type == REQ_EXECUTE);
		is_del = (req_q.req_type == REQ_DELETE);
		is_repl = (req_q.req_type == REQ_REPLACE);
		add_side = is_repl ? (old_q.is_ask ? SIDE_ASK : SIDE_BID) : req_q.side_code;
		add_ref = is_repl ? req_q.new_order_ref : req_q.order_ref;
		dup = new_hit_q;
		// replace adds its new order as a plain add in its second pass
		add_try = is_add;
		st_n = ST_OK;
		diff = {1'b0, old_q.qty} - {1'b0, req_q.quantity};
		we = 1'b0;
		waddr = old_idx_q;
		wdata = old_q;
		if (add_try) begin
			if ((add_side != SIDE_BID && add_side != SIDE_ASK) || dup)
				st_n = ST_BAD_SIDE;
			else if (!free_hit_q)
				st_n = ST_FULL;
			else begin
				we = 1'b1;
				waddr = free_idx_q;
				wdata.used = 1'b1;
				wdata.resting = 1'b1;
				wdata.ref_id = add_ref;
				wdata.price = req_q.price;
				wdata.qty = req_q.quantity;
				wdata.is_ask = (add_side == SIDE_ASK);
			end
		end else if ((is_red || is_del || is_repl) && !old_hit_q)
			st_n = ST_UNKNOWN;
		else if (is_red) begin
			if (!old_q.resting)
				st_n = ST_NOT_RESTING;
			else begin
				we = 1'b1;
				wdata.qty = diff[32] ? 32'd0 : diff[31:0];
				// an order reduced to zero leaves the book but keeps its slot
				wdata.resting = !diff[32] && (diff[31:0] != 32'd0);
				if (diff[32])
					st_n = ST_CLAMPED;
			end
		end else if (is_del || is_repl) begin
			// free the old slot; a replace adds the new order afterwards
			we = 1'b1;
			wdata.used = 1'b0;
			wdata.resting = 1'b0;
		end
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = idx_q[AW-1:0];
			wdata = '0;
		end else if (state_q != S_APPLY)
			we = 1'b0;
		ridx = ridx_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			err_q <= '0;
			rsp_valid <= 1'b0;
			idx_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					// one entry written per cycle
					if (idx_q == (AW+1)'(MAX_ORDERS - 1)) begin
						idx_q <= '0;
						state_q <= S_IDLE;
					end else
						idx_q <= idx_q + (AW+1)'(1);
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						idx_q <= '0;
						rvld_q <= 1'b0;
						old_hit_q <= 1'b0;
						new_hit_q <= 1'b0;
						free_hit_q <= 1'b0;
						old_idx_q <= '0;
						free_idx_q <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					// issue reads, compare the returning entry
					if (idx_q != (AW+1)'(MAX_ORDERS))
						idx_q <= idx_q + (AW+1)'(1);
					ridx_q <= idx_q;
					rvld_q <= (idx_q != (AW+1)'(MAX_ORDERS));
					if (rvld_q && !rdata.used && !free_hit_q) begin
						free_hit_q <= 1'b1;
						free_idx_q <= ridx;
					end
					if (rvld_q && rdata.used) begin
						if (rdata.ref_id == req_q.order_ref && !old_hit_q) begin
							old_hit_q <= 1'b1;
							old_idx_q <= ridx;
							old_q <= rdata;
						end
						// duplicate unless it is the slot being replaced away
						if (rdata.ref_id == ((req_q.req_type == REQ_REPLACE) ?
								req_q.new_order_ref : req_q.order_ref) &&
								!((req_q.req_type == REQ_REPLACE) &&
								rdata.ref_id == req_q.order_ref))
							new_hit_q <= 1'b1;
					end
					if (!rvld_q && idx_q == (AW+1)'(MAX_ORDERS))
						state_q <= S_APPLY;
				end
				S_APPLY: begin
					idx_q <= '0;
					rvld_q <= 1'b0;
					bid_q <= '0;
					ask_q <= '0;
					if (is_repl && old_hit_q) begin
						// second pass: add the new order now that the old is gone
						req_q.req_type <= REQ_ADD;
						req_q.order_ref <= req_q.new_order_ref;
						req_q.side_code <= old_q.is_ask ? SIDE_ASK : SIDE_BID;
						old_hit_q <= 1'b0;
						new_hit_q <= 1'b0;
						free_hit_q <= 1'b0;
						state_q <= S_FIND;
					end else begin
						st_q <= st_n;
						if (st_n != ST_OK && err_q != 32'hFFFF_FFFF)
							err_q <= err_q + 32'd1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q != (AW+1)'(MAX_ORDERS))
						idx_q <= idx_q + (AW+1)'(1);
					ridx_q <= idx_q;
					rvld_q <= (idx_q != (AW+1)'(MAX_ORDERS));
					if (rvld_q && rdata.used && rdata.resting) begin
						if (rdata.is_ask) begin
							if (!ask_q.found || rdata.price <= ask_q.price)
								ask_q <= level_step(ask_q, 1'b1, rdata.price, rdata.qty);
						end else begin
							if (!bid_q.found || rdata.price >= bid_q.price)
								bid_q <= level_step(bid_q, 1'b0, rdata.price, rdata.qty);
						end
					end
					if (!rvld_q && idx_q == (AW+1)'(MAX_ORDERS)) begin
						rsp.status <= st_q;
						rsp.error_total <= err_q;
						rsp.bid_valid <= bid_q.found;
						rsp.bid_price <= bid_q.price;
						rsp.bid_total_qty <= bid_q.total;
						rsp.bid_orders <= bid_q.cnt;
						rsp.ask_valid <= ask_q.found;
						rsp.ask_price <= ask_q.price;
						rsp.ask_total_qty <= ask_q.total;
						rsp.ask_orders <= ask_q.cnt;
						rsp_valid <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp_stall) begin
						rsp_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: design/lob_checker.sv
// lob_checker: port-level checks for the order book top level
// depends on lob_pkg; bound to limit_order_book_top_of_book
`timescale 1ns / 1ps
module lob_checker (
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input lob_pkg::rsp_t rsp
);
	import lob_pkg::*;
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while a result waits");
	a_bid_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.bid_valid |-> rsp.bid_orders == 9'd0)
		else $error("empty bid side reports orders");
	a_ask_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ask_valid |-> rsp.ask_orders == 9'd0)
		else $error("empty ask side reports orders");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_FULL)
		else $error("status code out of range");
endmodule

bind limit_order_book_top_of_book lob_checker u_lob_checker (
	.clk(clk), .arst_n(arst_n), .req_stall(req_stall),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);

// File: test/limit_order_book_top_of_book_tb.sv
// limit_order_book_top_of_book_tb: self-checking bench for the top-of-book order table
// depends on lob_pkg and limit_order_book_top_of_book; directed table, then random feed
`timescale 1ns / 1ps
module limit_order_book_top_of_book_tb;
	import lob_pkg::*;

	localparam int NSLOT = 256;
	localparam int N_RANDOM = 1730;
	localparam int IDLE_LIMIT = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	limit_order_book_top_of_book dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// book mirror kept by the predictor
	logic book_used[NSLOT];
	logic book_rest[NSLOT];
	logic [63:0] book_ref[NSLOT];
	logic [31:0] book_price[NSLOT];
	logic [31:0] book_qty[NSLOT];
	logic book_ask[NSLOT];
	logic [31:0] err_count;

	rsp_t pending_rsp[$];
	// some directed rows carry a typed-in status/book check; other rows only use the predictor
	logic pending_typed[$];
	rsp_t pending_typed_rsp[$];
	int fail_count = 0;
	int idle_cycles = 0;
	int n_sent = 0, n_got = 0, n_clamp = 0, n_full = 0;

	// recently used references so cancels, deletes and replaces hit live orders
	logic [63:0] live_refs[$];

	function automatic int find_ref(logic [63:0] r);
		for (int i = 0; i < NSLOT; i++)
			if (book_used[i] && book_ref[i] == r)
				return i;
		return -1;
	endfunction

	function automatic logic [2:0] book_add(logic [63:0] r, logic [31:0] p, logic [31:0] q,
			logic [7:0] s);
		if ((s != SIDE_BID && s != SIDE_ASK) || find_ref(r) >= 0)
			return ST_BAD_SIDE;
		for (int i = 0; i < NSLOT; i++)
			if (!book_used[i]) begin
				book_used[i] = 1'b1;
				book_rest[i] = 1'b1;
				book_ref[i] = r;
				book_price[i] = p;
				book_qty[i] = q;
				book_ask[i] = (s == SIDE_ASK);
				return ST_OK;
			end
		return ST_FULL;
	endfunction

	function automatic void best_of(logic want_ask, output logic v, output logic [31:0] p,
			output logic [39:0] tq, output logic [8:0] n);
		logic [40:0] sum;
		v = 1'b0; p = '0; tq = '0; n = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (!book_used[i] || !book_rest[i] || book_ask[i] != want_ask)
				continue;
			if (!v || (want_ask ? book_price[i] < p : book_price[i] > p)) begin
				v = 1'b1; p = book_price[i]; tq = '0; n = '0;
			end
			if (book_price[i] == p) begin
				sum = {1'b0, tq} + {9'd0, book_qty[i]};
				tq = sum[40] ? QTY40_MAX : sum[39:0];
				if (n != CNT9_MAX)
					n = n + 9'd1;
			end
		end
	endfunction

	function automatic rsp_t apply_message(req_t m);
		rsp_t o;
		logic [2:0] st;
		int i;
		logic [7:0] old_side;
		st = ST_OK;
		case (m.req_type)
			REQ_ADD: st = book_add(m.order_ref, m.price, m.quantity, m.side_code);
			REQ_CANCEL, REQ_EXECUTE: begin
				i = find_ref(m.order_ref);
				if (i < 0)
					st = ST_UNKNOWN;
				else if (!book_rest[i])
					st = ST_NOT_RESTING;
				else begin
					if (m.quantity <= book_qty[i])
						book_qty[i] = book_qty[i] - m.quantity;
					else begin
						book_qty[i] = '0;
						st = ST_CLAMPED;
					end
					if (book_qty[i] == 0)
						book_rest[i] = 1'b0;
				end
			end
			REQ_DELETE, REQ_REPLACE: begin
				i = find_ref(m.order_ref);
				if (i < 0)
					st = ST_UNKNOWN;
				else begin
					old_side = book_ask[i] ? SIDE_ASK : SIDE_BID;
					book_used[i] = 1'b0;
					book_rest[i] = 1'b0;
					if (m.req_type == REQ_REPLACE)
						st = book_add(m.new_order_ref, m.price, m.quantity, old_side);
				end
			end
			default: ;
		endcase
		if (st != ST_OK && err_count != 32'hFFFF_FFFF)
			err_count = err_count + 1;
		o.status = st;
		o.error_total = err_count;
		best_of(1'b0, o.bid_valid, o.bid_price, o.bid_total_qty, o.bid_orders);
		best_of(1'b1, o.ask_valid, o.ask_price, o.ask_total_qty, o.ask_orders);
		return o;
	endfunction

	// no gap mostly, a short one often, a long one now and then
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	// valid stays high between back-to-back transfers; it drops only for a gap
	task automatic send(req_t m, logic typed, rsp_t want);
		int gap;
		rsp_t exp_rsp;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= m;
		req_valid <= 1'b1;
		exp_rsp = apply_message(m);
		pending_rsp.insert(pending_rsp.size(), exp_rsp);
		pending_typed.insert(pending_typed.size(), typed);
		pending_typed_rsp.insert(pending_typed_rsp.size(), want);
		if (exp_rsp.status == ST_CLAMPED) n_clamp++;
		if (exp_rsp.status == ST_FULL) n_full++;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		n_sent++;
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) rsp_stall <= 1'b0;
		else if (r < 97) rsp_stall <= 1'b1;
		else rsp_stall <= ($urandom_range(0, 1) == 1);
	end

	// response checker: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		rsp_t e;
		rsp_t t;
		logic typed;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_got++;
			if (pending_rsp.size() == 0) begin
				$error("response with nothing expected: %h", rsp);
				fail_count++;
			end else begin
				e = pending_rsp.pop_front();
				typed = pending_typed.pop_front();
				t = pending_typed_rsp.pop_front();
				// a typed-in row must agree with the predictor too
				if (typed && t != e) begin
					$error("table row disagrees with predictor: table %h pred %h", t, e);
					fail_count++;
				end
				if (rsp.status != e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status); fail_count++; end
				if (rsp.error_total != e.error_total) begin
					$error("error_total exp %0d got %0d", e.error_total, rsp.error_total);
					fail_count++; end
				if (rsp.bid_valid != e.bid_valid) begin
					$error("bid_valid exp %0d got %0d", e.bid_valid, rsp.bid_valid);
					fail_count++; end
				if (rsp.bid_price != e.bid_price) begin
					$error("bid_price exp %0d got %0d", e.bid_price, rsp.bid_price);
					fail_count++; end
				if (rsp.bid_total_qty != e.bid_total_qty) begin
					$error("bid_total_qty exp %0d got %0d", e.bid_total_qty, rsp.bid_total_qty);
					fail_count++; end
				if (rsp.bid_orders != e.bid_orders) begin
					$error("bid_orders exp %0d got %0d", e.bid_orders, rsp.bid_orders);
					fail_count++; end
				if (rsp.ask_valid != e.ask_valid) begin
					$error("ask_valid exp %0d got %0d", e.ask_valid, rsp.ask_valid);
					fail_count++; end
				if (rsp.ask_price != e.ask_price) begin
					$error("ask_price exp %0d got %0d", e.ask_price, rsp.ask_price);
					fail_count++; end
				if (rsp.ask_total_qty != e.ask_total_qty) begin
					$error("ask_total_qty exp %0d got %0d", e.ask_total_qty, rsp.ask_total_qty);
					fail_count++; end
				if (rsp.ask_orders != e.ask_orders) begin
					$error("ask_orders exp %0d got %0d", e.ask_orders, rsp.ask_orders);
					fail_count++; end
			end
		end
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic req_t mk(logic [2:0] op, logic [63:0] r, logic [63:0] nr,
			logic [31:0] p, logic [31:0] q, logic [7:0] s);
		req_t m;
		m.req_type = op; m.order_ref = r; m.new_order_ref = nr;
		m.price = p; m.quantity = q; m.side_code = s;
		return m;
	endfunction

	// small reference space so adds collide and replaces reuse references
	function automatic logic [63:0] small_ref();
		return {30'd0, 2'($urandom_range(0, 3)), 20'd0, 12'($urandom_range(0, 4095))};
	endfunction

	// random message, biased toward live references so the book stays populated
	function automatic req_t random_message(int phase);
		req_t m;
		int r;
		logic [63:0] hit;
		m.new_order_ref = {$urandom, $urandom};
		m.order_ref = {$urandom, $urandom};
		// a narrow price band gives shared levels; occasional full-range values
		m.price = ($urandom_range(0, 9) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 6);
		m.quantity = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
		m.side_code = ($urandom_range(0, 1) == 1) ? SIDE_BID : SIDE_ASK;
		if ($urandom_range(0, 19) == 0) m.side_code = 8'($urandom);
		hit = (live_refs.size() > 0) ? live_refs[$urandom_range(0, live_refs.size() - 1)]
			: m.order_ref;
		r = $urandom_range(0, 99);
		// fill phase favors adds so the table reaches full, drain phase favors deletes
		if (r < (phase == 1 ? 75 : 35)) begin
			m.req_type = REQ_ADD;
			if ($urandom_range(0, 15) == 0) m.order_ref = hit;
			else m.order_ref = small_ref();
		end else begin
			r = $urandom_range(0, 99);
			if (r < 25) m.req_type = REQ_CANCEL;
			else if (r < 50) m.req_type = REQ_EXECUTE;
			else if (r < (phase == 2 ? 85 : 72)) m.req_type = REQ_DELETE;
			else if (r < 97) m.req_type = REQ_REPLACE;
			else m.req_type = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 9) != 0) m.order_ref = hit;
			if ($urandom_range(0, 7) == 0) m.new_order_ref = m.order_ref;
			else if ($urandom_range(0, 7) == 0 && live_refs.size() > 0) m.new_order_ref = hit;
			else m.new_order_ref = small_ref();
		end
		return m;
	endfunction

	typedef struct {
		req_t msg;
		logic typed;
		rsp_t want;
	} row_t;

	row_t dir_rows[$];
	localparam logic [63:0] R_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	function automatic rsp_t typed_rsp(logic [2:0] st, logic [31:0] errs);
		rsp_t o;
		o = '0;
		o.status = st;
		o.error_total = errs;
		return o;
	endfunction

	function automatic void add_row(req_t msg, logic typed, rsp_t want);
		row_t w;
		w.msg = msg;
		w.typed = typed;
		w.want = want;
		dir_rows.insert(dir_rows.size(), w);
	endfunction

	initial begin
		req_t m;
		rsp_t zero_rsp;
		int phase;
		for (int i = 0; i < NSLOT; i++) begin
			book_used[i] = 1'b0;
			book_rest[i] = 1'b0;
		end
		err_count = '0;
		zero_rsp = '0;

		// directed table; typed-in answers only where the book is empty
		add_row(mk(REQ_CANCEL, 64'd5, 0, 0, 1, 0), 1'b1, typed_rsp(ST_UNKNOWN, 1));
		add_row(mk(REQ_DELETE, R_MAX, 0, 0, 0, 0), 1'b1, typed_rsp(ST_UNKNOWN, 2));
		add_row(mk(REQ_REPLACE, 64'd0, 1, 0, 0, 0), 1'b1, typed_rsp(ST_UNKNOWN, 3));
		add_row(mk(REQ_ADD, 64'd1, 0, 5, 5, 8'd0), 1'b1, typed_rsp(ST_BAD_SIDE, 4));
		add_row(mk(REQ_ADD, 64'd1, 0, 5, 5, 8'hFF), 1'b1, typed_rsp(ST_BAD_SIDE, 5));
		add_row(mk(3'd5, R_MAX, R_MAX, '1, '1, '1), 1'b1, typed_rsp(ST_OK, 5));
		add_row(mk(3'd7, 0, 0, 0, 0, 0), 1'b1, typed_rsp(ST_OK, 5));
		// extremes of price and quantity on both sides, wide sums
		add_row(mk(REQ_ADD, R_MAX, 0, '1, '1, SIDE_BID), 1'b0, zero_rsp);
		add_row(mk(REQ_ADD, 64'd0, 0, '1, '1, SIDE_BID), 1'b0, zero_rsp);
		add_row(mk(REQ_ADD, 64'd2, 0, 0, '1, SIDE_ASK), 1'b0, zero_rsp);
		add_row(mk(REQ_ADD, 64'd3, 0, 0, 0, SIDE_ASK), 1'b0, zero_rsp);
		add_row(mk(REQ_ADD, 64'd0, 0, 7, 7, SIDE_ASK), 1'b0, zero_rsp);
		add_row(mk(REQ_CANCEL, 64'd3, 0, 0, 0, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_EXECUTE, R_MAX, 0, 0, 32'd10, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_EXECUTE, 64'd2, 0, 0, '1, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_CANCEL, 64'd2, 0, 0, 1, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_CANCEL, 64'd0, 0, 0, '1, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_REPLACE, R_MAX, R_MAX, 32'd9, 32'd4, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_REPLACE, R_MAX, 64'd2, 32'd9, 32'd4, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_DELETE, 64'd2, 0, 0, 0, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_DELETE, 64'd3, 0, 0, 0, 0), 1'b0, zero_rsp);
		add_row(mk(REQ_ADD, 64'h5555_AAAA_5555_AAAA, 0, 32'h5555_AAAA,
			32'hAAAA_5555, SIDE_ASK), 1'b0, zero_rsp);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send(dir_rows[k].msg, dir_rows[k].typed, dir_rows[k].want);

		// random feed: mixed, then fill to book-full, then drain
		for (int n = 0; n < N_RANDOM; n++) begin
			phase = (n < 600) ? 0 : (n < 1150) ? 1 : 2;
			m = random_message(phase);
			if (m.req_type == REQ_ADD) live_refs.insert(live_refs.size(), m.order_ref);
			if (m.req_type == REQ_REPLACE) live_refs.insert(live_refs.size(), m.new_order_ref);
			if (live_refs.size() > 300) void'(live_refs.pop_front());
			send(m, 1'b0, zero_rsp);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (2 * NSLOT + 20) @(posedge clk);

		$display("sent %0d messages, checked %0d responses", n_sent, n_got);
		$display("clamped reductions %0d, book-full rejections %0d", n_clamp, n_full);
		if (fail_count == 0 && pending_rsp.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
